### rtl/core/gics_pkg.sv
// Shared types and constants for the contour sum block.
// Holds the queue word formats, the front-to-back command and the register map.
// No dependencies.
`default_nettype none

package gics_pkg;

	// default sizing
	localparam int MAX_WIDTH_DEF  = 512;
	localparam int MAX_HEIGHT_DEF = 512;
	localparam int CHANNELS_DEF   = 3;

	// fixed field widths
	localparam int IN_CHANNELS = 3;
	localparam int PIX_W       = 8;
	localparam int COORD_W     = 9;
	localparam int DX_W        = COORD_W + 1;
	localparam int CFG_W       = 10;
	localparam int SUM_W       = 48;

	// command address room for the largest supported image (4096 x 4096)
	localparam int DIM_LIMIT  = 4096;
	localparam int CMD_ADDR_W = 2 * $clog2(DIM_LIMIT);

	localparam int CMD_FIFO_DEPTH = 2;

	// register map
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;
	localparam int REG_IDX_LSB = 2;
	localparam logic REG_IDX_WIDTH  = 1'b0;
	localparam logic REG_IDX_HEIGHT = 1'b1;
	localparam logic [CFG_W-1:0] CFG_DIM_RESET = CFG_W'(512);

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_POINT = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		logic               opcode;
		logic [PIX_W-1:0]   chan0;
		logic [PIX_W-1:0]   chan1;
		logic [PIX_W-1:0]   chan2;
		logic [COORD_W-1:0] point_x;
		logic [COORD_W-1:0] point_y;
		logic               last;
	} in_word_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum0;
		logic signed [SUM_W-1:0] sum1;
		logic signed [SUM_W-1:0] sum2;
		logic                    saturated;
	} out_word_t;

	// classified word handed from front to back
	typedef struct packed {
		cmd_kind_t                           kind;
		logic                                first_pt;
		logic                                last_pt;
		logic                                in_image;
		logic                                row_start;
		logic                                top_row;
		logic [CMD_ADDR_W-1:0]               addr;
		logic signed [DX_W-1:0]              dx;
		logic signed [DX_W-1:0]              dy;
		logic [IN_CHANNELS-1:0][PIX_W-1:0]   pix;
	} cmd_t;

endpackage

`default_nettype wire

### rtl/core/gics_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module gics_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/gics_cmd_fifo.sv
// Short command queue between the front and back parts.
// No dependencies.
`default_nettype none

module gics_cmd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);

	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/gics_front.sv
// Front part: accepts input words, tracks the load raster position and the
// contour chain, and issues classified commands. Depends on gics_pkg.
`default_nettype none

module gics_front #(
	parameter int MAX_WIDTH  = gics_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = gics_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	output logic                                 full,
	input  wire gics_pkg::in_word_t              item,
	input  wire logic [gics_pkg::CFG_W-1:0]      image_width,
	input  wire logic [gics_pkg::CFG_W-1:0]      image_height,
	input  wire logic                            q_full,
	output logic                                 q_push,
	output gics_pkg::cmd_t                       q_cmd
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int CX  = CW + 1;
	localparam int RX  = RW + 1;
	localparam int AWC = gics_pkg::CMD_ADDR_W;

	logic [CW-1:0]                col_q;
	logic [RW-1:0]                row_q;
	logic [gics_pkg::COORD_W-1:0] prev_x_q;
	logic [gics_pkg::COORD_W-1:0] prev_y_q;
	logic                         open_q;

	logic [CX-1:0] w_cl;
	logic [RX-1:0] h_cl;
	logic [CX-1:0] c0, cn, col_nx;
	logic [RX-1:0] r0, r1, rn, row_nx;
	logic          accept;
	logic          is_point;

	assign full     = q_full;
	assign accept   = push && !q_full;
	assign is_point = (item.opcode == gics_pkg::OP_POINT);
	assign q_push   = accept;

	// clamp the image size to 1..MAX
	always_comb begin
		if (image_width == '0) begin
			w_cl = CX'(1);
		end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
			w_cl = CX'(MAX_WIDTH);
		end else begin
			w_cl = CX'(image_width);
		end
		if (image_height == '0) begin
			h_cl = RX'(1);
		end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
			h_cl = RX'(MAX_HEIGHT);
		end else begin
			h_cl = RX'(image_height);
		end
	end

	// load position: wrap a stale position first, then advance past this pixel
	always_comb begin
		if (CX'(col_q) < w_cl) begin
			c0 = CX'(col_q);
			r1 = RX'(row_q);
		end else begin
			c0 = '0;
			r1 = RX'(row_q) + 1'b1;
		end
		r0 = (r1 >= h_cl) ? '0 : r1;
		cn = c0 + 1'b1;
		rn = r0 + 1'b1;
		if (cn >= w_cl) begin
			col_nx = '0;
			row_nx = (rn >= h_cl) ? '0 : rn;
		end else begin
			col_nx = cn;
			row_nx = r0;
		end
	end

	always_comb begin
		q_cmd           = '0;
		q_cmd.pix       = {item.chan2, item.chan1, item.chan0};
		q_cmd.last_pt   = item.last;
		if (is_point) begin
			q_cmd.kind     = gics_pkg::OP_POINT;
			q_cmd.first_pt = !open_q;
			q_cmd.in_image = (item.point_y != '0)
				&& (32'(item.point_x) < 32'(w_cl))
				&& (32'(item.point_y) <= 32'(h_cl));
			q_cmd.addr     = AWC'({RW'(item.point_y - 1'b1), CW'(item.point_x)});
			q_cmd.dx       = $signed({1'b0, item.point_x}) - $signed({1'b0, prev_x_q});
			q_cmd.dy       = $signed({1'b0, item.point_y}) - $signed({1'b0, prev_y_q});
		end else begin
			q_cmd.kind      = gics_pkg::OP_LOAD;
			q_cmd.row_start = (c0 == '0);
			q_cmd.top_row   = (r0 == '0);
			q_cmd.addr      = AWC'({r0[RW-1:0], c0[CW-1:0]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			open_q   <= 1'b0;
		end else if (accept) begin
			if (is_point) begin
				prev_x_q <= item.point_x;
				prev_y_q <= item.point_y;
				open_q   <= !item.last;
			end else begin
				col_q <= col_nx[CW-1:0];
				row_q <= row_nx[RW-1:0];
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/gics_back.sv
// Back part: runs each command against the map RAM, builds the maps on loads,
// accumulates contour sums on points and holds the result word. Depends on gics_pkg.
`default_nettype none

module gics_back #(
	parameter int MAX_WIDTH  = gics_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = gics_pkg::MAX_HEIGHT_DEF,
	parameter int CHANNELS   = gics_pkg::CHANNELS_DEF,
	parameter int AW         = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT),
	parameter int MAP_W      = 18
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              q_empty,
	output logic                                   q_pop,
	input  wire gics_pkg::cmd_t                    cmd,
	output logic                                   ram_rd_en,
	output logic [AW-1:0]                          ram_rd_addr,
	input  wire logic [2*CHANNELS*MAP_W-1:0]       ram_rd_data,
	output logic                                   ram_wr_en,
	output logic [AW-1:0]                          ram_wr_addr,
	output logic [2*CHANNELS*MAP_W-1:0]            ram_wr_data,
	output logic                                   empty,
	input  wire logic                              pop,
	output gics_pkg::out_word_t                    result
);

	localparam int SUM_W     = gics_pkg::SUM_W;
	localparam int PROD_W    = MAP_W + gics_pkg::DX_W;
	localparam int PSUM_W    = PROD_W + 1;
	localparam int ACC_X_W   = SUM_W + 2;
	localparam int N_OUT     = gics_pkg::IN_CHANNELS;
	localparam logic signed [SUM_W-1:0] ACC_MAX = {1'b0, {(SUM_W - 1){1'b1}}};
	localparam logic signed [SUM_W-1:0] ACC_MIN = {1'b1, {(SUM_W - 1){1'b0}}};
	localparam logic signed [ACC_X_W-1:0] ACC_MAX_X = ACC_X_W'(ACC_MAX);
	localparam logic signed [ACC_X_W-1:0] ACC_MIN_X = ACC_X_W'(ACC_MIN);
	// address distance between one map row and the next
	localparam logic [AW-1:0] ROW_STEP = AW'(1) << $clog2(MAX_WIDTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DATA,
		ST_SUM,
		ST_ACC,
		ST_FIN
	} state_t;

	state_t                    state_q;
	gics_pkg::cmd_t            cmd_q;
	logic                      out_valid_q;
	gics_pkg::out_word_t       result_q;
	logic                      sat_q;
	logic signed [MAP_W-1:0]   rsum_q    [CHANNELS];
	logic signed [SUM_W-1:0]   acc_q     [CHANNELS];
	logic signed [PROD_W-1:0]  prod_p_s1 [CHANNELS];
	logic signed [PROD_W-1:0]  prod_q_s1 [CHANNELS];
	logic signed [PSUM_W-1:0]  psum_s2   [CHANNELS];

	logic [CHANNELS-1:0][MAP_W-1:0] rd_p, rd_q, wr_p, wr_q;
	logic [gics_pkg::PIX_W-1:0]     pix_c    [CHANNELS];
	logic signed [MAP_W-1:0]        pix_w    [CHANNELS];
	logic signed [MAP_W-1:0]        p_above  [CHANNELS];
	logic signed [MAP_W-1:0]        q_base   [CHANNELS];
	logic signed [MAP_W-1:0]        pv       [CHANNELS];
	logic signed [MAP_W-1:0]        qv       [CHANNELS];
	logic signed [PROD_W-1:0]       prod_p   [CHANNELS];
	logic signed [PROD_W-1:0]       prod_q   [CHANNELS];
	logic signed [ACC_X_W-1:0]      acc_sum  [CHANNELS];
	logic signed [SUM_W-1:0]        acc_nx   [CHANNELS];
	logic [CHANNELS-1:0]            ovf;
	logic signed [SUM_W-1:0]        emit_sum [N_OUT];
	logic                           use_map;
	logic                           is_load;
	logic                           emit;

	assign {rd_p, rd_q}  = ram_rd_data;
	assign ram_wr_data   = {wr_p, wr_q};

	assign q_pop       = (state_q == ST_IDLE) && !q_empty;
	assign ram_rd_en   = q_pop;
	// a load reads the entry one row above its own; a point reads its own address
	assign ram_rd_addr = (cmd.kind == gics_pkg::OP_LOAD) ? cmd.addr[AW-1:0] - ROW_STEP
		: cmd.addr[AW-1:0];
	assign is_load     = (cmd_q.kind == gics_pkg::OP_LOAD);
	assign ram_wr_en   = (state_q == ST_DATA) && is_load;
	assign ram_wr_addr = cmd_q.addr[AW-1:0];
	assign use_map     = cmd_q.in_image && !cmd_q.first_pt;
	assign emit        = (state_q == ST_FIN) && cmd_q.last_pt && (!out_valid_q || pop);
	assign empty       = !out_valid_q;
	assign result      = result_q;

	// channels past the input fields load as zero
	for (genvar g = 0; g < CHANNELS; g++) begin : g_pix
		if (g < N_OUT) begin : g_in
			assign pix_c[g] = cmd_q.pix[g];
		end else begin : g_zero
			assign pix_c[g] = '0;
		end
	end

	// channels past CHANNELS report zero
	for (genvar g = 0; g < N_OUT; g++) begin : g_emit
		if (g < CHANNELS) begin : g_live
			assign emit_sum[g] = acc_q[g];
		end else begin : g_zero
			assign emit_sum[g] = '0;
		end
	end

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			pix_w[c]   = $signed(MAP_W'(pix_c[c]));
			p_above[c] = cmd_q.top_row ? '0 : $signed(rd_p[c]);
			q_base[c]  = cmd_q.row_start ? '0 : rsum_q[c];
			wr_p[c]    = p_above[c] - pix_w[c];
			wr_q[c]    = q_base[c] + pix_w[c];
			pv[c]      = use_map ? $signed(rd_p[c]) : '0;
			qv[c]      = use_map ? $signed(rd_q[c]) : '0;
			prod_p[c]  = cmd_q.dx * pv[c];
			prod_q[c]  = cmd_q.dy * qv[c];
			acc_sum[c] = ACC_X_W'(acc_q[c]) + ACC_X_W'(psum_s2[c]);
			ovf[c]     = 1'b0;
			if (acc_sum[c] > ACC_MAX_X) begin
				acc_nx[c] = ACC_MAX;
				ovf[c]    = 1'b1;
			end else if (acc_sum[c] < ACC_MIN_X) begin
				acc_nx[c] = ACC_MIN;
				ovf[c]    = 1'b1;
			end else begin
				acc_nx[c] = acc_sum[c][SUM_W-1:0];
			end
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_DATA) begin
			for (int c = 0; c < CHANNELS; c++) begin
				prod_p_s1[c] <= prod_p[c];
				prod_q_s1[c] <= prod_q[c];
			end
		end
		if (state_q == ST_SUM) begin
			for (int c = 0; c < CHANNELS; c++) begin
				psum_s2[c] <= PSUM_W'(prod_p_s1[c]) + PSUM_W'(prod_q_s1[c]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			result_q    <= '0;
			sat_q       <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				rsum_q[c] <= '0;
				acc_q[c]  <= '0;
			end
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_DATA;
					end
				end
				ST_DATA: begin
					if (is_load) begin
						for (int c = 0; c < CHANNELS; c++) begin
							rsum_q[c] <= wr_q[c];
						end
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					for (int c = 0; c < CHANNELS; c++) begin
						acc_q[c] <= acc_nx[c];
					end
					if (|ovf) begin
						sat_q <= 1'b1;
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!cmd_q.last_pt) begin
						state_q <= ST_IDLE;
					end else if (emit) begin
						result_q.sum0      <= emit_sum[0];
						result_q.sum1      <= emit_sum[1];
						result_q.sum2      <= emit_sum[2];
						result_q.saturated <= sat_q;
						sat_q              <= 1'b0;
						for (int c = 0; c < CHANNELS; c++) begin
							acc_q[c] <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN && cmd_q.last_pt))
		else $error("result word appeared without a closing contour point");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (!sat_q && acc_q[0] == '0))
		else $error("accumulators not cleared after a contour closed");

	a_hold_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && cmd_q.last_pt && out_valid_q && !pop) |=> state_q == ST_FIN)
		else $error("closing point left FIN while the result slot was occupied");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr_en |-> (!ram_rd_en && $past(ram_rd_en)))
		else $error("map write not paired with the preceding read of its load");

endmodule

`default_nettype wire

### rtl/core/green_integral_contour_sum.sv
// Top level of the Green-theorem contour sum block.
// Depends on gics_pkg, gics_front, gics_cmd_fifo, gics_back and gics_ram.
//
// Words come in through a queue-style port (push/full) and are one of two kinds.
// A load word carries one three-channel pixel; pixels arrive in raster order over
// an image of image_width x image_height (clamped to 1..MAX_WIDTH/MAX_HEIGHT).
// For each pixel the block stores, per channel, the row prefix sum and the negated
// column prefix sum. A point word carries one contour point; every point after
// the first of a contour adds dx*P + dy*Q, read one row above the point, to a
// 48-bit signed accumulator per channel. Reads above row 0 or outside the loaded
// image use zero. The point marked last emits one result word (plain integer sums,
// saturate flag) through a queue-style port (empty/pop) and restarts the contour.
// Accumulators saturate to the 48-bit limits and set the flag. Flow: a front stage
// classifies each word in the cycle it is accepted and drops it into a two-entry
// command queue, so push stays open while the back end works until that queue
// fills. The back end takes one command at a time: a load word as a registered map
// read, then the map write, and a point word as map read, multiply, product sum,
// saturating accumulate and emit. A closing point waits in its final state while
// the result register still holds an unpopped word. The map RAM holds
// 2^(ceil(log2 MAX_WIDTH) + ceil(log2 MAX_HEIGHT)) rows; its contents are
// undefined until loaded and there is no clearing pass, so contour points must
// only read pixels loaded since reset. Configure only while the block is idle.

`default_nettype none

module green_integral_contour_sum #(
	parameter int MAX_WIDTH  = gics_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = gics_pkg::MAX_HEIGHT_DEF,
	parameter int CHANNELS   = gics_pkg::CHANNELS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [gics_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [gics_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [gics_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                    pready,
	// input words
	input  wire logic                               push,
	output logic                                    full,
	input  wire gics_pkg::in_word_t                 item,
	// result words
	output logic                                    empty,
	input  wire logic                               pop,
	output gics_pkg::out_word_t                     result
);

	localparam int CW      = $clog2(MAX_WIDTH);
	localparam int RW      = $clog2(MAX_HEIGHT);
	localparam int AW      = CW + RW;
	localparam int DEPTH   = 2 ** AW;
	localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	// signed width that holds a full row or column sum of 8-bit pixels
	localparam int MAP_W   = $clog2(MAX_DIM * ((1 << gics_pkg::PIX_W) - 1) + 1) + 1;
	localparam int RAM_W   = 2 * CHANNELS * MAP_W;
	localparam int CMD_W   = $bits(gics_pkg::cmd_t);

	logic [gics_pkg::CFG_W-1:0] width_q;
	logic [gics_pkg::CFG_W-1:0] height_q;
	logic                       cfg_wr;
	logic                       reg_idx;

	logic                 q_full;
	logic                 q_push;
	gics_pkg::cmd_t       front_cmd;
	logic [CMD_W-1:0]     q_rd_data;
	logic                 q_empty;
	logic                 q_pop;

	logic                 ram_rd_en;
	logic [AW-1:0]        ram_rd_addr;
	logic [RAM_W-1:0]     ram_rd_data;
	logic                 ram_wr_en;
	logic [AW-1:0]        ram_wr_addr;
	logic [RAM_W-1:0]     ram_wr_data;

	// ---- register port: always ready, write in the access phase ----
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[gics_pkg::REG_IDX_LSB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= gics_pkg::CFG_DIM_RESET;
			height_q <= gics_pkg::CFG_DIM_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				gics_pkg::REG_IDX_WIDTH: begin
					width_q <= pwdata[gics_pkg::CFG_W-1:0];
				end
				gics_pkg::REG_IDX_HEIGHT: begin
					height_q <= pwdata[gics_pkg::CFG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			gics_pkg::REG_IDX_WIDTH:  prdata = gics_pkg::APB_DATA_W'(width_q);
			gics_pkg::REG_IDX_HEIGHT: prdata = gics_pkg::APB_DATA_W'(height_q);
			default:                  prdata = '0;
		endcase
	end

	// ---- front: classify and track raster / contour position ----
	gics_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.item         (item),
		.image_width  (width_q),
		.image_height (height_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_cmd        (front_cmd)
	);

	// ---- decoupling queue ----
	gics_cmd_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (gics_pkg::CMD_FIFO_DEPTH)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (front_cmd),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rd_data),
		.empty   (q_empty)
	);

	// ---- back: map build, contour accumulate, result register ----
	gics_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.CHANNELS   (CHANNELS),
		.AW         (AW),
		.MAP_W      (MAP_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.cmd         (gics_pkg::cmd_t'(q_rd_data)),
		.ram_rd_en   (ram_rd_en),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.empty       (empty),
		.pop         (pop),
		.result      (result)
	);

	// ---- P and Q maps, one row per pixel, {P of every channel, Q of every channel} ----
	gics_ram #(
		.WIDTH (RAM_W),
		.DEPTH (DEPTH)
	) u_map_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

endmodule

`default_nettype wire

### dv/tb_green_integral_contour_sum.sv
`timescale 1ns / 100ps
// Testbench for green_integral_contour_sum: pixel loads and contour points go in through
// the push/full port, each contour sum is predicted locally and checked at the pop port.
// Depends on gics_pkg and the block's RTL.

module tb_green_integral_contour_sum;
	import gics_pkg::*;

	localparam int MAP_W        = MAX_WIDTH_DEF;
	localparam int MAP_H        = MAX_HEIGHT_DEF;
	localparam int MAP_DEPTH    = MAP_W * MAP_H;
	localparam int RANDOM_WORDS = 1700;
	localparam int SETTLE       = 32;      // covers a full command queue of point words
	localparam int PRINT_CAP    = 40;
	localparam longint SUM_HI   = (longint'(1) <<< (SUM_W - 1)) - 1;
	localparam longint SUM_LO   = -(longint'(1) <<< (SUM_W - 1));

	// ports
	logic                  clk     = 1'b0;
	logic                  arst_n  = 1'b0;
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [APB_ADDR_W-1:0] paddr   = '0;
	logic [APB_DATA_W-1:0] pwdata  = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  push    = 1'b0;
	logic                  full;
	in_word_t              item    = '0;
	logic                  empty;
	logic                  pop     = 1'b0;
	out_word_t             result;

	green_integral_contour_sum u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.push    (push),
		.full    (full),
		.item    (item),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	always #4 clk = ~clk;

	// A word waiting to be pushed, with the sums it is going to close out (if any).
	typedef struct {
		in_word_t  word;
		bit        closes;
		out_word_t sums;
	} queued_word_t;

	queued_word_t words_to_send[$];
	out_word_t    sums_due[$];

	// Local copy of the block's state. Maps are integers, one entry per pixel
	// and channel, addressed row * MAP_W + col exactly like the block's RAM.
	int     map_p [0:MAP_DEPTH-1][0:IN_CHANNELS-1];
	int     map_q [0:MAP_DEPTH-1][0:IN_CHANNELS-1];
	bit     loaded [0:MAP_DEPTH-1];
	int     loaded_at[$];              // every map entry written so far, for point picking
	int     ld_col = 0;
	int     ld_row = 0;
	int     row_sum [0:IN_CHANNELS-1] = '{0, 0, 0};
	int     last_x = 0;
	int     last_y = 0;
	bit     in_contour = 1'b0;
	longint acc [0:IN_CHANNELS-1] = '{0, 0, 0};
	bit     acc_sat = 1'b0;
	int     cfg_w = CFG_DIM_RESET;     // raw register contents, clamped where used
	int     cfg_h = CFG_DIM_RESET;

	// run bookkeeping
	int errors    = 0;
	int n_loads   = 0;
	int n_points  = 0;
	int n_checked = 0;
	int n_phases  = 0;
	int stuck_row = 0;                 // nonzero: next load would read an unwritten row above
	bit calm      = 1'b0;              // no idling on either side during this phase

	// handshake state
	bit           in_taken  = 1'b0;
	bit           out_taken = 1'b0;
	int           push_wait = 0;
	int           pop_wait  = 0;
	logic         next_push;
	logic         next_pop;
	queued_word_t sent;

	task automatic flag_mismatch(string msg);
		errors++;
		if (errors <= PRINT_CAP)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	function automatic int clamp_dim(int v, int hi);
		if (v < 1)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Position the next load word lands on. A column past the current width moves to
	// the next row and a row past the height wraps to the top, which is what happens
	// when the dimensions change in the middle of an image.
	function automatic void next_slot(output int col, output int row);
		col = ld_col;
		row = ld_row;
		if (col >= clamp_dim(cfg_w, MAP_W)) begin
			col = 0;
			row++;
		end
		if (row >= clamp_dim(cfg_h, MAP_H))
			row = 0;
	endfunction

	// True when a point at (x, y) takes its P and Q from the map rather than zero.
	function automatic bit reads_map(int x, int y);
		return y >= 1 && x < clamp_dim(cfg_w, MAP_W) && y - 1 < clamp_dim(cfg_h, MAP_H);
	endfunction

	function automatic bit safe_point(int x, int y);
		return !reads_map(x, y) || loaded[(y - 1) * MAP_W + x];
	endfunction

	function automatic void store_pixel(in_word_t w);
		int col, row, idx, pix, above, c;
		logic [PIX_W-1:0] chan [0:IN_CHANNELS-1];
		chan[0] = w.chan0;
		chan[1] = w.chan1;
		chan[2] = w.chan2;
		next_slot(col, row);
		idx = row * MAP_W + col;
		for (c = 0; c < IN_CHANNELS; c++) begin
			pix        = chan[c];
			row_sum[c] = (col == 0) ? pix : row_sum[c] + pix;
			above      = (row == 0) ? 0 : map_p[idx - MAP_W][c];
			map_q[idx][c] = row_sum[c];
			map_p[idx][c] = above - pix;
		end
		if (!loaded[idx]) begin
			loaded[idx] = 1'b1;
			loaded_at.push_back(idx);
		end
		// advance; the last pixel of the image brings the position back to the origin
		col++;
		if (col >= clamp_dim(cfg_w, MAP_W)) begin
			col = 0;
			row++;
			if (row >= clamp_dim(cfg_h, MAP_H))
				row = 0;
		end
		ld_col = col;
		ld_row = row;
	endfunction

	// One contour point; returns 1 with the closing sums when the point is marked last.
	function automatic bit integrate_point(in_word_t w, output out_word_t sums);
		int     x, y, idx, c;
		bit     in_image;
		longint dx, dy, s;
		x    = w.point_x;
		y    = w.point_y;
		sums = '0;
		// the first point of a contour only records where the walk starts
		if (in_contour) begin
			dx       = longint'(x) - longint'(last_x);
			dy       = longint'(y) - longint'(last_y);
			in_image = reads_map(x, y);
			idx      = in_image ? (y - 1) * MAP_W + x : 0;
			for (c = 0; c < IN_CHANNELS; c++) begin
				s = acc[c];
				if (in_image)
					s = s + dx * map_p[idx][c] + dy * map_q[idx][c];
				if (s > SUM_HI) begin
					s       = SUM_HI;
					acc_sat = 1'b1;
				end
				if (s < SUM_LO) begin
					s       = SUM_LO;
					acc_sat = 1'b1;
				end
				acc[c] = s;
			end
		end
		last_x     = x;
		last_y     = y;
		in_contour = 1'b1;
		if (!w.last)
			return 1'b0;
		sums.sum0      = SUM_W'(acc[0]);
		sums.sum1      = SUM_W'(acc[1]);
		sums.sum2      = SUM_W'(acc[2]);
		sums.saturated = acc_sat;
		for (c = 0; c < IN_CHANNELS; c++)
			acc[c] = 0;
		acc_sat    = 1'b0;
		in_contour = 1'b0;
		return 1'b1;
	endfunction

	// Predict the word now (the queue drains in order and the dimensions only change
	// between phases) and hand it to the driver.
	task automatic queue_word(in_word_t w);
		queued_word_t qw;
		qw.word   = w;
		qw.closes = 1'b0;
		qw.sums   = '0;
		if (w.opcode == OP_LOAD) begin
			store_pixel(w);
			n_loads++;
		end else begin
			qw.closes = integrate_point(w, qw.sums);
			n_points++;
		end
		words_to_send.push_back(qw);
	endtask

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	function automatic logic [PIX_W-1:0] pick_pixel();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	// Point fields ride along on load words with random content.
	task automatic queue_load(logic [PIX_W-1:0] c0, logic [PIX_W-1:0] c1, logic [PIX_W-1:0] c2);
		in_word_t w;
		w.opcode  = OP_LOAD;
		w.chan0   = c0;
		w.chan1   = c1;
		w.chan2   = c2;
		w.point_x = COORD_W'($urandom);
		w.point_y = COORD_W'($urandom);
		w.last    = 1'($urandom);
		queue_word(w);
	endtask

	task automatic queue_point(int x, int y, bit closing);
		in_word_t w;
		w.opcode  = OP_POINT;
		w.chan0   = PIX_W'($urandom);
		w.chan1   = PIX_W'($urandom);
		w.chan2   = PIX_W'($urandom);
		w.point_x = COORD_W'(x);
		w.point_y = COORD_W'(y);
		w.last    = closing;
		queue_word(w);
	endtask

	// Load the next pixel unless its column prefix would come from a row that was
	// never written; in that case hold loads off until the dimensions change.
	task automatic try_load(output bit ok);
		int col, row;
		next_slot(col, row);
		ok = (row == 0) || loaded[(row - 1) * MAP_W + col];
		if (!ok)
			stuck_row = row;
		else
			queue_load(pick_pixel(), pick_pixel(), pick_pixel());
	endtask

	// A tidy point reads a map entry that holds data; a loose one lands anywhere in the
	// coordinate range. Either is pulled to row 0 if it would read an unwritten entry.
	task automatic send_point(bit tidy, bit closing);
		int x, y, idx, tries;
		x = $urandom_range(0, MAP_W - 1);
		y = $urandom_range(0, MAP_H - 1);
		if (tidy && loaded_at.size() > 0) begin
			for (tries = 0; tries < 8; tries++) begin
				idx = loaded_at[$urandom_range(0, loaded_at.size() - 1)];
				x   = idx % MAP_W;
				y   = idx / MAP_W + 1;
				if (y < MAP_H && reads_map(x, y))
					break;
			end
		end
		if (y >= MAP_H || !safe_point(x, y))
			y = 0;
		queue_point(x, y, closing);
	endtask

	task automatic send_contour(int len);
		int i;
		bit open_end;
		open_end = ($urandom_range(0, 9) == 0);   // leave it open: it runs on into the next
		for (i = 0; i < len; i++)
			send_point($urandom_range(0, 9) < 8, i == len - 1 && !open_end);
	endtask

	// Wait for the block to go idle: everything sent, every sum popped, pipeline flushed.
	task automatic drain();
		while (words_to_send.size() > 0 || push || sums_due.size() > 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Register write in setup and access cycles, then a read back of the same register.
	task automatic write_reg(logic idx, int unsigned value);
		logic [APB_DATA_W-1:0] data, back;
		data = value & ((1 << CFG_W) - 1);
		if ($urandom_range(0, 3) == 0)
			data[APB_DATA_W-1:CFG_W] = (APB_DATA_W - CFG_W)'($urandom);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'(idx) << REG_IDX_LSB;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		back = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (back !== APB_DATA_W'(data[CFG_W-1:0]))
			flag_mismatch($sformatf("register %0d reads 0x%0h, wrote 0x%0h", idx, back, data));
		if (idx == REG_IDX_WIDTH)
			cfg_w = data[CFG_W-1:0];
		else
			cfg_h = data[CFG_W-1:0];
	endtask

	// One phase: new dimensions, then a mix of load bursts and contours.
	task automatic run_phase(int kind);
		int w, h, goal, n, i;
		bit ok;
		case (kind)
			0:       begin w = 0;                        h = 0;                       end
			1:       begin w = 1023;                     h = 1023;                    end
			2:       begin w = 512;                      h = $urandom_range(1, 3);    end
			3:       begin w = 1;                        h = $urandom_range(1, 16);   end
			4:       begin w = $urandom_range(513, 1023); h = $urandom_range(1, 4);   end
			default: begin w = $urandom_range(1, 12);    h = $urandom_range(1, 10);   end
		endcase
		// a height at or below the stuck row sends the next load back to row 0
		if (stuck_row > 0) begin
			h         = $urandom_range(1, stuck_row);
			stuck_row = 0;
		end
		write_reg(REG_IDX_WIDTH, w);
		write_reg(REG_IDX_HEIGHT, h);
		calm = ($urandom_range(0, 3) == 0);
		goal = n_loads + n_points + $urandom_range(30, 70);
		while (n_loads + n_points < goal) begin
			if ($urandom_range(0, 99) < 35 && stuck_row == 0) begin
				n  = $urandom_range(1, 10);
				ok = 1'b1;
				for (i = 0; i < n && ok; i++)
					try_load(ok);
			end else begin
				send_contour($urandom_range(1, 6));
			end
		end
		n_phases++;
		drain();
	endtask

	// ------------------------------------------------------------------
	// Driver: words change on the falling edge, one at a time from the queue.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			push      <= 1'b0;
			push_wait = 0;
		end else begin
			next_push = push;
			// the held word went in at the last rising edge: its sums are now due
			if (push && in_taken) begin
				if (sent.closes)
					sums_due.push_back(sent.sums);
				next_push = 1'b0;
				push_wait = calm ? 0 : $urandom_range(0, 4);
			end
			if (!next_push) begin
				if (push_wait > 0) begin
					push_wait--;
				end else if (words_to_send.size() > 0) begin
					sent = words_to_send.pop_front();
					item <= sent.word;
					next_push = 1'b1;
				end
			end
			push <= next_push;
		end
	end

	// Result side: hold pop high until a word is taken, then drop it for a drawn stall, if one is drawn.
	always @(negedge clk) begin
		if (!arst_n) begin
			pop      <= 1'b0;
			pop_wait = 0;
		end else begin
			next_pop = pop;
			if (pop && out_taken) begin
				pop_wait = calm ? 0 : $urandom_range(0, 4);
				next_pop = (pop_wait == 0);
			end else if (!pop) begin
				if (pop_wait > 0)
					pop_wait--;
				if (pop_wait == 0)
					next_pop = 1'b1;
			end
			pop <= next_pop;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: sample both handshakes on the rising edge, check each popped word.
	// ------------------------------------------------------------------
	task automatic check_sums(out_word_t got);
		out_word_t want;
		if (sums_due.size() == 0) begin
			flag_mismatch($sformatf("result word with no contour closed: sum0=%0d", got.sum0));
			return;
		end
		want = sums_due.pop_front();
		n_checked++;
		if (got.sum0 !== want.sum0)
			flag_mismatch($sformatf("sum0 %0d, predicted %0d", got.sum0, want.sum0));
		if (got.sum1 !== want.sum1)
			flag_mismatch($sformatf("sum1 %0d, predicted %0d", got.sum1, want.sum1));
		if (got.sum2 !== want.sum2)
			flag_mismatch($sformatf("sum2 %0d, predicted %0d", got.sum2, want.sum2));
		if (got.saturated !== want.saturated)
			flag_mismatch($sformatf("saturated %b, predicted %b", got.saturated, want.saturated));
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_taken  <= 1'b0;
			out_taken <= 1'b0;
		end else begin
			in_taken  <= push && !full;
			out_taken <= pop && !empty;
			if (pop && !empty)
				check_sums(result);
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		int i, goal;
		int  dir_x [0:7];
		int  dir_y [0:7];
		bit  dir_last [0:7];
		dir_x    = '{2, 0, 3, 3, 1, 511, 4, 0};
		dir_y    = '{1, 0, 0, 3, 2, 511, 1, 3};
		dir_last = '{1, 0, 0, 0, 0, 0,   0, 1};

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: a 4 x 3 image with all-zero and all-ones pixels up front, then a
		// lone closing point (zero sums), a contour that starts, steps along row 0
		// (nothing above it), reads the bottom row, leaves the image on both axes and
		// past the last column, and closes inside.
		write_reg(REG_IDX_WIDTH, 4);
		write_reg(REG_IDX_HEIGHT, 3);
		queue_load('0, '0, '0);
		queue_load('1, '1, '1);
		for (i = 2; i < 12; i++)
			queue_load(pick_pixel(), pick_pixel(), pick_pixel());
		for (i = 0; i < 8; i++)
			queue_point(dir_x[i], dir_y[i], dir_last[i]);
		drain();

		// Random phases; the first five walk the dimension extremes.
		goal = n_loads + n_points + RANDOM_WORDS;
		for (i = 0; n_loads + n_points < goal; i++)
			run_phase(i < 5 ? i : $urandom_range(5, 11) - (($urandom_range(0, 3) == 0) ? 5 : 0));
		drain();

		if (sums_due.size() > 0)
			flag_mismatch($sformatf("%0d contour sums never came out", sums_due.size()));
		$display("covered %0d pixel loads and %0d contour points over %0d dimension settings;",
			n_loads, n_points, n_phases + 1);
		$display("%0d contour sums compared, %0d mismatches", n_checked, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Hang guard: stop the run with a failure if it never finishes.
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

### sim.f
rtl/core/gics_pkg.sv
rtl/core/gics_ram.sv
rtl/core/gics_cmd_fifo.sv
rtl/core/gics_front.sv
rtl/core/gics_back.sv
rtl/core/green_integral_contour_sum.sv
dv/tb_green_integral_contour_sum.sv
